// ===== sv/fmba_pkg.sv =====
package fmba_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = $clog2(MAP_WORDS);
    localparam int BIT_AW      = $clog2(WORD_BITS);

    // Field widths fixed by the interface.
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 12;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 13;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_ENTRIES);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_SET   = 2'd1,
        CMD_TEST  = 2'd2,
        CMD_ALLOC = 2'd3
    } cmd_code_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITOP,
        ST_SCAN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic scan_step;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_alloc;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/fmba_ram.sv =====
module fmba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/fmba_ctrl.sv =====
module fmba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fmba_pkg::dp_stat_t  stat,
    output fmba_pkg::ctrl_cmd_t cmd
);

    fmba_pkg::state_t state_reg;
    fmba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fmba_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = stat.in_alloc ? fmba_pkg::ST_SCAN : fmba_pkg::ST_BITOP;
                end
            end
            fmba_pkg::ST_BITOP:
            begin
                if (stat.out_free)
                begin
                    state_next = fmba_pkg::ST_IDLE;
                end
            end
            fmba_pkg::ST_SCAN:
            begin
                if (stat.scan_done && stat.out_free)
                begin
                    state_next = fmba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fmba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            fmba_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                cmd.rd_en   = s_tvalid;
            end
            fmba_pkg::ST_BITOP:
            begin
                cmd.finish = stat.out_free;
            end
            fmba_pkg::ST_SCAN:
            begin
                // The scan keeps walking words while the result slot is busy;
                // it only waits once the answer is known.
                if (stat.scan_done)
                begin
                    cmd.finish = stat.out_free;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    cmd.rd_en     = 1'b1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/fmba_dp.sv =====
module fmba_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fmba_pkg::ctrl_cmd_t                 cmd,
    output fmba_pkg::dp_stat_t                  stat,
    input  logic [fmba_pkg::IN_W-1:0]           s_tdata,
    input  logic                                cfg_valid,
    input  logic [fmba_pkg::LIMIT_W-1:0]        cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fmba_pkg::OUT_W-1:0]          m_tdata
);

    fmba_pkg::cmd_code_t                  in_cmd;
    logic [fmba_pkg::IDX_W-1:0]           in_idx;

    fmba_pkg::cmd_code_t                  cmd_reg;
    logic [fmba_pkg::IDX_W-1:0]           idx_reg;
    logic [fmba_pkg::WORD_AW-1:0]         scan_word_reg;
    logic [fmba_pkg::LIMIT_W-1:0]         limit_reg;
    logic [fmba_pkg::MAP_WORDS-1:0]       valid_reg;
    logic                                 rd_valid_reg;

    logic                                 out_valid_reg;
    fmba_pkg::status_t                    status_reg;
    logic                                 bit_reg;
    logic [fmba_pkg::IDX_W-1:0]           alloc_reg;

    logic [fmba_pkg::WORD_AW-1:0]         raddr;
    logic [fmba_pkg::WORD_AW-1:0]         waddr;
    logic [fmba_pkg::WORD_BITS-1:0]       ram_q;
    logic [fmba_pkg::WORD_BITS-1:0]       word;
    logic [fmba_pkg::WORD_BITS-1:0]       wdata;
    logic                                 wr_en;

    logic [fmba_pkg::LIMIT_W-1:0]         lim;
    logic [fmba_pkg::LIMIT_W-1:0]         base;
    logic [fmba_pkg::LIMIT_W-1:0]         remaining;
    logic [fmba_pkg::WORD_BITS-1:0]       free_mask;
    logic [fmba_pkg::BIT_AW-1:0]          free_pos;
    logic                                 found;
    logic                                 last_word;
    logic                                 in_range;
    logic [fmba_pkg::WORD_BITS-1:0]       bit_mask;
    logic [fmba_pkg::WORD_BITS-1:0]       alloc_mask;
    logic                                 out_free;

    fmba_pkg::status_t                    status_next;
    logic                                 bit_next;
    logic [fmba_pkg::IDX_W-1:0]           alloc_next;

    assign in_cmd = fmba_pkg::cmd_code_t'(s_tdata[fmba_pkg::CMD_W-1:0]);
    assign in_idx = s_tdata[fmba_pkg::CMD_W +: fmba_pkg::IDX_W];

    // Limits above the map capacity are clamped to it.
    assign lim = (limit_reg > fmba_pkg::LIMIT_RESET) ? fmba_pkg::LIMIT_RESET : limit_reg;

    always_comb
    begin
        if (cmd.capture)
        begin
            raddr = (in_cmd == fmba_pkg::CMD_ALLOC) ? '0
                                                    : in_idx[fmba_pkg::BIT_AW +: fmba_pkg::WORD_AW];
        end
        else
        begin
            raddr = fmba_pkg::WORD_AW'(scan_word_reg + 1'b1);
        end
    end

    fmba_ram #(
        .WIDTH (fmba_pkg::WORD_BITS),
        .DEPTH (fmba_pkg::MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // A word never written since reset reads as all free.
    assign word = rd_valid_reg ? ram_q : '0;

    // Scan window: only bits below the limit may be handed out.
    assign base      = fmba_pkg::LIMIT_W'({scan_word_reg, {fmba_pkg::BIT_AW{1'b0}}});
    assign remaining = lim - base;
    assign last_word = (remaining <= fmba_pkg::LIMIT_W'(fmba_pkg::WORD_BITS));

    always_comb
    begin
        for (int b = 0; b < fmba_pkg::WORD_BITS; b++)
        begin
            free_mask[b] = !word[b] && (fmba_pkg::LIMIT_W'(b) < remaining);
        end
    end

    always_comb
    begin
        free_pos = '0;
        for (int b = fmba_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_mask[b])
            begin
                free_pos = fmba_pkg::BIT_AW'(b);
            end
        end
    end

    assign found      = |free_mask;
    assign in_range   = ({1'b0, idx_reg} < lim);
    assign bit_mask   = fmba_pkg::WORD_BITS'(1) << idx_reg[fmba_pkg::BIT_AW-1:0];
    assign alloc_mask = fmba_pkg::WORD_BITS'(1) << free_pos;
    assign out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        wr_en       = 1'b0;
        waddr       = idx_reg[fmba_pkg::BIT_AW +: fmba_pkg::WORD_AW];
        wdata       = word;
        status_next = fmba_pkg::STAT_OK;
        bit_next    = 1'b0;
        alloc_next  = '0;
        case (cmd_reg)
            fmba_pkg::CMD_CLEAR:
            begin
                wdata = word & ~bit_mask;
                wr_en = cmd.finish && in_range;
                if (!in_range)
                begin
                    status_next = fmba_pkg::STAT_RANGE;
                end
            end
            fmba_pkg::CMD_SET:
            begin
                wdata = word | bit_mask;
                wr_en = cmd.finish && in_range;
                if (!in_range)
                begin
                    status_next = fmba_pkg::STAT_RANGE;
                end
            end
            fmba_pkg::CMD_TEST:
            begin
                if (!in_range)
                begin
                    status_next = fmba_pkg::STAT_RANGE;
                end
                else
                begin
                    bit_next = word[idx_reg[fmba_pkg::BIT_AW-1:0]];
                end
            end
            default:
            begin
                waddr = scan_word_reg;
                wdata = word | alloc_mask;
                wr_en = cmd.finish && found;
                if (found)
                begin
                    alloc_next = fmba_pkg::IDX_W'({scan_word_reg, free_pos});
                end
                else
                begin
                    status_next = fmba_pkg::STAT_FULL;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= fmba_pkg::LIMIT_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (wr_en)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg       <= in_cmd;
            idx_reg       <= in_idx;
            scan_word_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_word_reg <= scan_word_reg + 1'b1;
        end
        if (cmd.rd_en)
        begin
            rd_valid_reg <= valid_reg[raddr];
        end
        if (cmd.finish)
        begin
            status_reg <= status_next;
            bit_reg    <= bit_next;
            alloc_reg  <= alloc_next;
        end
    end

    assign stat.in_alloc  = (in_cmd == fmba_pkg::CMD_ALLOC);
    assign stat.scan_done = found || last_word;
    assign stat.out_free  = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, alloc_reg, bit_reg, status_reg};

endmodule

// ===== sv/free_map_bit_allocator_core.sv =====
// Bitmap entry allocator: one used bit per entry, all free after reset, kept
// in a 128 x 32 word RAM whose never-written words read as free through a
// bank of per-word valid flops. Clear, set and test read their word as the
// item is accepted; clear and set then write it back once the output
// register is free. The allocate scan reads one bitmap word per cycle
// through the RAM read port (always at least one) and stops at the first
// word holding a free entry below the limit, or at the word where the limit
// ends, also while the output register is busy. A finished result sits in
// the output register until taken; the next item is taken once the current
// one has moved into that register. The limit register (cfg_data, reset 4096,
// clamped to 4096) may be written only while no item is in progress.
module free_map_bit_allocator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: command[1:0], entry_index[13:2], zero pad[15:14].
    input  logic [fmba_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: status[1:0], bit_value[2], allocated_index[14:3], zero pad[15].
    output logic [fmba_pkg::OUT_W-1:0]        m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fmba_pkg::LIMIT_W-1:0]      cfg_data
);

    fmba_pkg::ctrl_cmd_t cmd;
    fmba_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    fmba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fmba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== bench/tb.sv =====
module tb;
    import fmba_pkg::*;

    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 160;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TAIL_CYCLES  = 150;

    typedef struct packed {
        status_t          status;
        logic             bit_value;
        logic [IDX_W-1:0] alloc_idx;
    } alloc_result_t;

    typedef struct {
        bit               is_cfg;
        logic [LIMIT_W-1:0] cfg_value;
        cmd_code_t        cmd;
        logic [IDX_W-1:0] idx;
        bit               typed;
        alloc_result_t    res;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;

    // Shadow of the block: one used bit per entry and the limit register.
    logic [MAX_ENTRIES-1:0] used_map;
    logic [LIMIT_W-1:0]     limit_reg;

    alloc_result_t pending_results[$];
    plan_row_t     plan[$];

    // Typed expectation that travels with the item currently offered.
    bit            offer_typed;
    alloc_result_t offer_result;

    bit  calm;
    bit  hold_request;
    int  stall_left;
    int  cycle_count;
    int  mismatches;
    int  items_done;
    int  grants;
    int  full_reports;
    int  range_reports;
    int  limits_tried;

    free_map_bit_allocator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int active_limit();
        return (limit_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(limit_reg);
    endfunction

    function automatic alloc_result_t predict_access(cmd_code_t cmd, logic [IDX_W-1:0] idx);
        alloc_result_t r;
        int lim;
        r = '{STAT_OK, 1'b0, '0};
        lim = active_limit();
        if (cmd == CMD_ALLOC)
        begin
            r.status = STAT_FULL;
            for (int i = 0; i < lim; i++)
            begin
                if (!used_map[i])
                begin
                    used_map[i] = 1'b1;
                    r.status    = STAT_OK;
                    r.alloc_idx = i[IDX_W-1:0];
                    break;
                end
            end
        end
        else if (int'(idx) >= lim)
            r.status = STAT_RANGE;
        else if (cmd == CMD_CLEAR)
            used_map[idx] = 1'b0;
        else if (cmd == CMD_SET)
            used_map[idx] = 1'b1;
        else
            r.bit_value = used_map[idx];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic cmd_code_t pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return CMD_ALLOC;
        if (r < 55)
            return CMD_SET;
        if (r < 80)
            return CMD_CLEAR;
        return CMD_TEST;
    endfunction

    function automatic logic [IDX_W-1:0] pick_idx();
        int r;
        int lim;
        r   = $urandom_range(99);
        lim = active_limit();
        if (r < 60 && lim > 0)
            return IDX_W'($urandom_range(lim - 1));
        if (r < 75)
            return IDX_W'($urandom);
        if (r < 85)
            return ($urandom_range(1) != 0) ? '1 : '0;
        // Just below or at the limit, where the range check flips.
        if (lim > 0 && $urandom_range(1) != 0)
            return IDX_W'(lim - 1);
        return (lim >= MAX_ENTRIES) ? '1 : IDX_W'(lim);
    endfunction

    function automatic logic [LIMIT_W-1:0] phase_limit(int p);
        case (p)
            0:       return LIMIT_W'(4096);
            1:       return LIMIT_W'($urandom_range(1, 40));
            2:       return LIMIT_W'(32);
            3:       return LIMIT_W'($urandom_range(1, 4096));
            4:       return LIMIT_W'(33);
            5:       return '1;
            6:       return LIMIT_W'($urandom_range(1, 64));
            7:       return '0;
            8:       return LIMIT_W'($urandom_range(0, 8191));
            default: return LIMIT_W'(4096);
        endcase
    endfunction

    function automatic void add_row(cmd_code_t cmd, logic [IDX_W-1:0] idx, bit typed,
                                    status_t st, logic bitv, logic [IDX_W-1:0] aidx);
        plan_row_t pr;
        pr.is_cfg    = 1'b0;
        pr.cfg_value = '0;
        pr.cmd       = cmd;
        pr.idx       = idx;
        pr.typed     = typed;
        pr.res       = '{st, bitv, aidx};
        plan.push_back(pr);
    endfunction

    function automatic void add_limit_row(logic [LIMIT_W-1:0] v);
        plan_row_t pr;
        pr.is_cfg    = 1'b1;
        pr.cfg_value = v;
        pr.cmd       = CMD_CLEAR;
        pr.idx       = '0;
        pr.typed     = 1'b0;
        pr.res       = '{STAT_OK, 1'b0, '0};
        plan.push_back(pr);
    endfunction

    task automatic send_item(cmd_code_t cmd, logic [IDX_W-1:0] idx, bit typed,
                             alloc_result_t res);
        int gap;
        gap = calm ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        offer_typed  = typed;
        offer_result = res;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, cmd};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limits_tried++;
    endtask

    // Receiver: random stalls, a long hold-off on request, none in calm phases.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (calm || !rst_n)
                m_tready <= rst_n;
            else
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    m_tready <= 1'b0;
                    stall_left--;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // Scoreboard: results are checked before new items are predicted, so a
    // spurious result can never pair with an item accepted at the same edge.
    always @(posedge clk)
    begin
        alloc_result_t want;
        alloc_result_t got;
        alloc_result_t pred;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status    = status_t'(m_tdata[1:0]);
                got.bit_value = m_tdata[2];
                got.alloc_idx = m_tdata[14:3];
                if (pending_results.size() == 0)
                begin
                    $error("result with no item outstanding: tdata %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    items_done++;
                    if (want.status == STAT_FULL)
                        full_reports++;
                    else if (want.status == STAT_RANGE)
                        range_reports++;
                    if (got.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        mismatches++;
                    end
                    if (got.bit_value !== want.bit_value)
                    begin
                        $error("bit_value mismatch: expected %0d, actual %0d",
                               want.bit_value, got.bit_value);
                        mismatches++;
                    end
                    if (got.alloc_idx !== want.alloc_idx)
                    begin
                        $error("allocated_index mismatch: expected %0d, actual %0d",
                               want.alloc_idx, got.alloc_idx);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                pred = predict_access(cmd_code_t'(s_tdata[1:0]), s_tdata[13:2]);
                if (cmd_code_t'(s_tdata[1:0]) == CMD_ALLOC && pred.status == STAT_OK)
                    grants++;
                pending_results.push_back(offer_typed ? offer_result : pred);
            end
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        used_map     = '0;
        limit_reg    = LIMIT_RESET;
        offer_typed  = 1'b0;
        offer_result = '{STAT_OK, 1'b0, '0};
        calm         = 1'b0;
        hold_request = 1'b0;
        stall_left   = 0;
        cycle_count  = 0;
        mismatches   = 0;
        items_done   = 0;
        grants       = 0;
        full_reports = 0;
        range_reports = 0;
        limits_tried = 0;

        // Directed part, starting from the reset limit of 4096.
        add_row(CMD_TEST,  12'd0,    1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_TEST,  12'd4095, 1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_ALLOC, 12'd4095, 1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_ALLOC, 12'd0,    1, STAT_OK,    1'b0, 12'd1);
        add_row(CMD_TEST,  12'd0,    1, STAT_OK,    1'b1, 12'd0);
        add_row(CMD_SET,   12'd4095, 1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_SET,   12'd4095, 1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_TEST,  12'd4095, 1, STAT_OK,    1'b1, 12'd0);
        add_row(CMD_CLEAR, 12'd4095, 1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_CLEAR, 12'd4095, 1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_CLEAR, 12'd0,    1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_ALLOC, 12'd0,    1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_SET,   12'd2,    1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_ALLOC, 12'd0,    0, STAT_OK,    1'b0, 12'd0);
        // Single entry, already taken: the map is full.
        add_limit_row(13'd1);
        add_row(CMD_ALLOC, 12'd0,    1, STAT_FULL,  1'b0, 12'd0);
        add_row(CMD_TEST,  12'd1,    1, STAT_RANGE, 1'b0, 12'd0);
        add_row(CMD_SET,   12'd4095, 1, STAT_RANGE, 1'b0, 12'd0);
        add_row(CMD_CLEAR, 12'd0,    1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_ALLOC, 12'd0,    1, STAT_OK,    1'b0, 12'd0);
        // A limit of zero manages no entry at all.
        add_limit_row(13'd0);
        add_row(CMD_TEST,  12'd0,    1, STAT_RANGE, 1'b0, 12'd0);
        add_row(CMD_ALLOC, 12'd0,    1, STAT_FULL,  1'b0, 12'd0);
        add_row(CMD_CLEAR, 12'd0,    1, STAT_RANGE, 1'b0, 12'd0);
        // A limit above capacity acts as the full capacity.
        add_limit_row(13'h1FFF);
        add_row(CMD_TEST,  12'd4095, 1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_SET,   12'd4095, 1, STAT_OK,    1'b0, 12'd0);
        add_row(CMD_ALLOC, 12'd0,    0, STAT_OK,    1'b0, 12'd0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_for_results();
                write_limit(plan[i].cfg_value);
            end
            else
                send_item(plan[i].cmd, plan[i].idx, plan[i].typed, plan[i].res);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_for_results();
            write_limit(phase_limit(p));
            calm = (p % 4 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 3 && n == 60)
                    hold_request = 1'b1;
                if (p == 6 && n == 80)
                    wait_for_results();
                send_item(pick_cmd(), pick_idx(), 1'b0, '{STAT_OK, 1'b0, '0});
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d items over %0d limit settings in %0d cycles.",
                 items_done, limits_tried, cycle_count);
        $display("Allocate granted %0d entries; %0d full and %0d out-of-range reports.",
                 grants, full_reports, range_reports);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== free_map_bit_allocator_core.f =====
sv/fmba_pkg.sv
sv/fmba_ram.sv
sv/fmba_ctrl.sv
sv/fmba_dp.sv
sv/free_map_bit_allocator_core.sv
bench/tb.sv
